### rtl/lcnc_pkg.sv
// package for the luhn card number classifier: sizes, verdict codes,
// control structs, sequencer states and the brand decode function
// no dependencies
`timescale 1ns / 1ps

package lcnc_pkg;

  localparam int unsigned NumberWidth = 63;
  localparam int unsigned NumDigits   = 20;
  localparam int unsigned BcdWidth    = 4 * NumDigits;
  localparam int unsigned CountWidth  = 5;
  localparam int unsigned VerdictWidth = 3;

  localparam logic [VerdictWidth-1:0] VerdictBadSum    = 3'd0;
  localparam logic [VerdictWidth-1:0] VerdictUnknown   = 3'd1;
  localparam logic [VerdictWidth-1:0] VerdictAmex      = 3'd2;
  localparam logic [VerdictWidth-1:0] VerdictMastercard = 3'd3;
  localparam logic [VerdictWidth-1:0] VerdictVisa      = 3'd4;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StScan,
    StFin
  } lcnc_state_e;

  // binary to bcd converter controls
  typedef struct packed {
    logic load;
    logic dbl;
    logic shift_out;
  } lcnc_conv_ctl_t;

  // digit scanner controls
  typedef struct packed {
    logic clear;
    logic step;
  } lcnc_scan_ctl_t;

  // digit scanner status
  typedef struct packed {
    logic [CountWidth-1:0] count;
    logic                  sum_zero;
    logic [3:0]            lead_hi;
    logic [3:0]            lead_lo;
  } lcnc_scan_t;

  function automatic logic [VerdictWidth-1:0] classify(
    input logic [3:0]            hi,
    input logic [3:0]            lo,
    input logic [CountWidth-1:0] count
  );
    logic [VerdictWidth-1:0] v;
    v = VerdictUnknown;
    if (hi == 4'd3 && (lo == 4'd4 || lo == 4'd7) && count == 5'd15) begin
      v = VerdictAmex;
    end else if (hi == 4'd5 && lo >= 4'd1 && lo <= 4'd5 && count == 5'd16) begin
      v = VerdictMastercard;
    end else if (hi == 4'd4 && lo <= 4'd9 && (count == 5'd13 || count == 5'd16)) begin
      v = VerdictVisa;
    end
    return v;
  endfunction

endpackage

### rtl/lcnc_bcd_conv.sv
// bit-serial binary to bcd converter (shift and add-3), then a nibble
// shifter that presents the decimal digits least significant first
// depends on lcnc_pkg
`timescale 1ns / 1ps

module lcnc_bcd_conv #(
  parameter int unsigned NUMBER_WIDTH = lcnc_pkg::NumberWidth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lcnc_pkg::lcnc_conv_ctl_t    ctl_i,
  input  logic [NUMBER_WIDTH-1:0]     number_i,
  output logic [3:0]                  digit_o
);

  logic [NUMBER_WIDTH-1:0]          bin_q, bin_d;
  logic [lcnc_pkg::BcdWidth-1:0]    bcd_q, bcd_d;
  logic [lcnc_pkg::BcdWidth-1:0]    bcd_adj;

  // add 3 to every nibble of five or more
  always_comb begin
    for (int i = 0; i < lcnc_pkg::NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    if (ctl_i.load) begin
      bin_d = number_i;
      bcd_d = '0;
    end else if (ctl_i.dbl) begin
      bin_d = {bin_q[NUMBER_WIDTH-2:0], 1'b0};
      bcd_d = {bcd_adj[lcnc_pkg::BcdWidth-2:0], bin_q[NUMBER_WIDTH-1]};
    end else if (ctl_i.shift_out) begin
      bcd_d = {4'd0, bcd_q[lcnc_pkg::BcdWidth-1:4]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q <= '0;
      bcd_q <= '0;
    end else begin
      bin_q <= bin_d;
      bcd_q <= bcd_d;
    end
  end

  assign digit_o = bcd_q[3:0];

endmodule

### rtl/lcnc_digit_scan.sv
// digit scanner: one decimal digit a cycle while step is high, luhn sum mod 10, digit count
// and the two leading digits
// depends on lcnc_pkg
`timescale 1ns / 1ps

module lcnc_digit_scan (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lcnc_pkg::lcnc_scan_ctl_t ctl_i,
  input  logic [3:0]               digit_i,
  output lcnc_pkg::lcnc_scan_t     stat_o
);

  logic [lcnc_pkg::CountWidth-1:0] pos_q, pos_d;
  logic [lcnc_pkg::CountWidth-1:0] count_q, count_d;
  logic [3:0]                      sum_q, sum_d;
  logic [3:0]                      prev_q, prev_d;
  logic [3:0]                      hi_q, hi_d;
  logic [3:0]                      lo_q, lo_d;
  logic [4:0]                      doubled;
  logic [3:0]                      contrib;
  logic [4:0]                      sum_raw;

  always_comb begin
    doubled = {digit_i, 1'b0};
    if (pos_q[0]) begin
      contrib = (doubled >= 5'd10) ? 4'(doubled - 5'd9) : doubled[3:0];
    end else begin
      contrib = digit_i;
    end
    sum_raw = {1'b0, sum_q} + {1'b0, contrib};
  end

  always_comb begin
    pos_d   = pos_q;
    count_d = count_q;
    sum_d   = sum_q;
    prev_d  = prev_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    if (ctl_i.clear) begin
      pos_d   = '0;
      count_d = '0;
      sum_d   = '0;
      prev_d  = '0;
      hi_d    = '0;
      lo_d    = '0;
    end else if (ctl_i.step) begin
      pos_d  = pos_q + 1'b1;
      prev_d = digit_i;
      sum_d  = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];
      // a nonzero digit is the highest one seen so far
      if (digit_i != 4'd0) begin
        count_d = pos_q + 1'b1;
        hi_d    = digit_i;
        lo_d    = prev_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q <= count_d;
    sum_q   <= sum_d;
    prev_q  <= prev_d;
    hi_q    <= hi_d;
    lo_q    <= lo_d;
  end

  assign stat_o.count    = count_q;
  assign stat_o.sum_zero = (sum_q == 4'd0);
  assign stat_o.lead_hi  = hi_q;
  assign stat_o.lead_lo  = lo_q;

endmodule

### rtl/luhn_card_number_classifier.sv
// luhn card number classifier top level: sequencer, converter, scanner
// and result register
// depends on lcnc_pkg, lcnc_bcd_conv, lcnc_digit_scan
//
// channel  | signals                               | dir | handshake
// ---------+---------------------------------------+-----+------------------------
// command  | start_i, busy_o, card_number_i        | in  | start_i && !busy_o
// result   | valid_o, digit_count_o, luhn_ok_o,    | out | valid_o, one-cycle strobe
//          | verdict_o                             |     |
//
// an item goes from acceptance to the result strobe through the sequencer states:
// StConv for the shift-and-add-3 binary to bcd conversion, StScan to walk the
// decimal digits, StFin to decode the brand.
// one item at a time; busy_o is high while an item is in work.
// reset clears the sequencer and the result strobe; the receiver cannot stall.
`timescale 1ns / 1ps

module luhn_card_number_classifier #(
  parameter int unsigned NUMBER_WIDTH = lcnc_pkg::NumberWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [NUMBER_WIDTH-1:0]             card_number_i,
  output logic                                valid_o,
  output logic [lcnc_pkg::CountWidth-1:0]     digit_count_o,
  output logic                                luhn_ok_o,
  output logic [lcnc_pkg::VerdictWidth-1:0]   verdict_o
);

  localparam int unsigned CntW = $clog2(NUMBER_WIDTH + 1);

  lcnc_pkg::lcnc_state_e    state_q, state_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  lcnc_pkg::lcnc_conv_ctl_t conv_ctl;
  lcnc_pkg::lcnc_scan_ctl_t scan_ctl;
  lcnc_pkg::lcnc_scan_t     scan_stat;
  logic [3:0]               digit;
  logic                     accept;
  logic                     last_conv;
  logic                     last_scan;

  logic                                valid_q, valid_d;
  logic [lcnc_pkg::CountWidth-1:0]     count_q;
  logic                                ok_q;
  logic [lcnc_pkg::VerdictWidth-1:0]   verdict_q;

  assign accept    = start_i && (state_q == lcnc_pkg::StIdle);
  assign last_conv = (cnt_q == CntW'(NUMBER_WIDTH - 1));
  assign last_scan = (cnt_q == CntW'(lcnc_pkg::NumDigits - 1));

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      lcnc_pkg::StIdle: begin
        if (start_i) begin
          state_d = lcnc_pkg::StConv;
          cnt_d   = '0;
        end
      end
      lcnc_pkg::StConv: begin
        if (last_conv) begin
          state_d = lcnc_pkg::StScan;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      lcnc_pkg::StScan: begin
        if (last_scan) begin
          state_d = lcnc_pkg::StFin;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      lcnc_pkg::StFin: begin
        state_d = lcnc_pkg::StIdle;
      end
      default: begin
        state_d = lcnc_pkg::StIdle;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    conv_ctl = '0;
    scan_ctl = '0;
    valid_d  = 1'b0;
    busy_o   = 1'b1;
    unique case (state_q)
      lcnc_pkg::StIdle: begin
        busy_o         = 1'b0;
        conv_ctl.load  = start_i;
        scan_ctl.clear = start_i;
      end
      lcnc_pkg::StConv: begin
        conv_ctl.dbl = 1'b1;
      end
      lcnc_pkg::StScan: begin
        conv_ctl.shift_out = 1'b1;
        scan_ctl.step      = 1'b1;
      end
      lcnc_pkg::StFin: begin
        valid_d = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcnc_pkg::StIdle;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  lcnc_bcd_conv #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_conv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (conv_ctl),
    .number_i (card_number_i),
    .digit_o  (digit)
  );

  lcnc_digit_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (scan_ctl),
    .digit_i (digit),
    .stat_o  (scan_stat)
  );

  // result register, loaded in the final cycle of an item
  always_ff @(posedge clk_i) begin
    if (valid_d) begin
      count_q <= scan_stat.count;
      ok_q    <= scan_stat.sum_zero;
      if (scan_stat.sum_zero) begin
        verdict_q <= lcnc_pkg::classify(scan_stat.lead_hi, scan_stat.lead_lo,
                                        scan_stat.count);
      end else begin
        verdict_q <= lcnc_pkg::VerdictBadSum;
      end
    end
  end

  assign valid_o       = valid_q;
  assign digit_count_o = count_q;
  assign luhn_ok_o     = ok_q;
  assign verdict_o     = verdict_q;

  // the result strobe only comes once the sequencer is back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |-> !busy_o)
    else $error("result strobe while busy");

  // an accepted item always makes the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> busy_o)
    else $error("accepted item did not start work");

  // a bad checksum verdict exactly when the luhn check fails
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((verdict_o == lcnc_pkg::VerdictBadSum) == !luhn_ok_o))
    else $error("verdict disagrees with luhn check");

  // the strobe lasts one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

endmodule

### dv/lcnc_verdict_checker.sv
// checker for the luhn card number classifier: watches the command and result
// channels, predicts digit count, luhn flag and verdict of every item, compares
// depends on lcnc_pkg
`timescale 1ns / 1ps

module lcnc_verdict_checker #(
  parameter int unsigned NUMBER_WIDTH = lcnc_pkg::NumberWidth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              busy_i,
  input  logic [NUMBER_WIDTH-1:0]           card_number_i,
  input  logic                              valid_i,
  input  logic [lcnc_pkg::CountWidth-1:0]   digit_count_i,
  input  logic                              luhn_ok_i,
  input  logic [lcnc_pkg::VerdictWidth-1:0] verdict_i,
  output int unsigned                       pending_o,
  output int unsigned                       fail_count_o
);

  typedef struct packed {
    logic [lcnc_pkg::CountWidth-1:0]   digit_count;
    logic                              luhn_ok;
    logic [lcnc_pkg::VerdictWidth-1:0] verdict;
  } card_result_t;

  card_result_t expected_results[$];
  int unsigned  mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic card_result_t card_verdict(input logic [NUMBER_WIDTH-1:0] number);
    logic [63:0]  rest;
    logic [63:0]  lead;
    int unsigned  digit;
    int unsigned  doubled;
    int unsigned  sum;
    int unsigned  count;
    card_result_t res;
    rest  = 64'(number);
    lead  = rest;
    sum   = 0;
    count = 0;
    while (rest != 64'd0) begin
      digit = int'(rest % 64'd10);
      rest  = rest / 64'd10;
      if (count % 2 == 0) begin
        sum += digit;
      end else begin
        doubled = digit * 2;
        sum += doubled / 10 + doubled % 10;
      end
      count++;
    end
    while (lead >= 64'd100) begin
      lead = lead / 64'd10;
    end
    res.digit_count = count[lcnc_pkg::CountWidth-1:0];
    res.luhn_ok     = (sum % 10 == 0);
    if (!res.luhn_ok) begin
      res.verdict = lcnc_pkg::VerdictBadSum;
    end else if ((lead == 64'd34 || lead == 64'd37) && count == 15) begin
      res.verdict = lcnc_pkg::VerdictAmex;
    end else if (lead >= 64'd51 && lead <= 64'd55 && count == 16) begin
      res.verdict = lcnc_pkg::VerdictMastercard;
    end else if (lead >= 64'd40 && lead <= 64'd49 && (count == 13 || count == 16)) begin
      res.verdict = lcnc_pkg::VerdictVisa;
    end else begin
      res.verdict = lcnc_pkg::VerdictUnknown;
    end
    return res;
  endfunction

  task automatic note_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    card_result_t want;
    if (!rst_ni) begin
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (valid_i) begin
        if (expected_results.size() == 0) begin
          note_mismatch("result with no item in work, verdict", verdict_i, 0);
        end else begin
          want = expected_results.pop_front();
          if (digit_count_i !== want.digit_count) begin
            note_mismatch("digit_count", digit_count_i, want.digit_count);
          end
          if (luhn_ok_i !== want.luhn_ok) begin
            note_mismatch("luhn_ok", luhn_ok_i, want.luhn_ok);
          end
          if (verdict_i !== want.verdict) begin
            note_mismatch("verdict", verdict_i, want.verdict);
          end
        end
      end
      if (start_i && !busy_i) begin
        expected_results.push_back(card_verdict(card_number_i));
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

### dv/luhn_card_number_classifier_tb.sv
// testbench top for the luhn card number classifier: clock, reset, card
// number stimulus with random pacing, watchdog and final verdict
// depends on lcnc_pkg, luhn_card_number_classifier, lcnc_verdict_checker
`timescale 1ns / 1ps

module luhn_card_number_classifier_tb;

  localparam int unsigned NumberWidth = lcnc_pkg::NumberWidth;
  localparam int unsigned Latency     = NumberWidth + 21;
  localparam int unsigned RandomItems = 750;
  localparam int unsigned QuietLimit  = 2000;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic [NumberWidth-1:0]            card_number = '0;
  logic                              busy;
  logic                              valid;
  logic [lcnc_pkg::CountWidth-1:0]   digit_count;
  logic                              luhn_ok;
  logic [lcnc_pkg::VerdictWidth-1:0] verdict;
  int unsigned                       pending;
  int unsigned                       fail_count;
  int unsigned                       quiet_cycles = 0;
  logic                              pace_idle = 1'b1;

  luhn_card_number_classifier #(
    .NUMBER_WIDTH (NumberWidth)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_o        (busy),
    .card_number_i (card_number),
    .valid_o       (valid),
    .digit_count_o (digit_count),
    .luhn_ok_o     (luhn_ok),
    .verdict_o     (verdict)
  );

  lcnc_verdict_checker #(
    .NUMBER_WIDTH (NumberWidth)
  ) u_verdict_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_i        (busy),
    .card_number_i (card_number),
    .valid_i       (valid),
    .digit_count_i (digit_count),
    .luhn_ok_i     (luhn_ok),
    .verdict_i     (verdict),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // luhn-valid number with the given two leading digits (only the first for length two) and length
  function automatic logic [NumberWidth-1:0] make_card(input int unsigned lead2,
                                                       input int unsigned ndig);
    int unsigned digits[20];
    int unsigned sum;
    int unsigned doubled;
    logic [63:0] value;
    for (int i = 0; i < 20; i++) begin
      digits[i] = $urandom_range(9);
    end
    digits[ndig-1] = lead2 / 10;
    if (ndig > 2) begin
      digits[ndig-2] = lead2 % 10;
    end
    sum = 0;
    for (int i = 1; i < ndig; i++) begin
      if (i % 2 == 1) begin
        doubled = 2 * digits[i];
        sum += doubled / 10 + doubled % 10;
      end else begin
        sum += digits[i];
      end
    end
    digits[0] = (10 - sum % 10) % 10;
    value = 64'd0;
    for (int i = ndig - 1; i >= 0; i--) begin
      value = value * 64'd10 + 64'(digits[i]);
    end
    return value[NumberWidth-1:0];
  endfunction

  // nudge the last digit so the checksum fails
  function automatic logic [NumberWidth-1:0] spoil_check(input logic [NumberWidth-1:0] n);
    return (n % 10 == 9) ? n - 1'b1 : n + 1'b1;
  endfunction

  function automatic logic [NumberWidth-1:0] random_card();
    int unsigned     pick;
    int unsigned     lead2;
    int unsigned     ndig;
    logic [63:0]     raw;
    logic [NumberWidth-1:0] n;
    pick = $urandom_range(99);
    if (pick < 55) begin
      case ($urandom_range(2))
        0: begin
          lead2 = $urandom_range(1) ? 37 : 34;
          ndig  = 15;
        end
        1: begin
          lead2 = $urandom_range(55, 51);
          ndig  = 16;
        end
        default: begin
          lead2 = $urandom_range(49, 40);
          ndig  = $urandom_range(1) ? 16 : 13;
        end
      endcase
      n = make_card(lead2, ndig);
      if ($urandom_range(99) < 20) begin
        n = spoil_check(n);
      end
    end else if (pick < 75) begin
      n = make_card($urandom_range(89, 10), $urandom_range(19, 2));
    end else if (pick < 90) begin
      raw = {$urandom, $urandom};
      n   = raw[NumberWidth-1:0] >> $urandom_range(NumberWidth - 1);
    end else if (pick < 95) begin
      // brand prefix with a length near the right one
      n = make_card($urandom_range(56, 33), $urandom_range(17, 12));
    end else begin
      n = NumberWidth'($urandom_range(999));
    end
    return n;
  endfunction

  task automatic send_card(input logic [NumberWidth-1:0] n);
    if (pace_idle && $urandom_range(99) < 32) begin
      start <= 1'b0;
      repeat ($urandom_range(100, 1)) @(posedge clk);
    end
    start       <= 1'b1;
    card_number <= n;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("luhn_card_number_classifier verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes and special cases
    send_card('0);
    send_card(NumberWidth'(5));
    send_card(NumberWidth'(18));
    send_card('1);
    send_card(NumberWidth'(1) << (NumberWidth - 1));
    send_card(NumberWidth'(64'd1000000000000000000));
    send_card(NumberWidth'(64'd999999999999999999));
    send_card(make_card(89, 19));
    send_card(make_card(34, 15));
    send_card(make_card(37, 15));
    send_card(make_card(34, 16));
    send_card(make_card(33, 15));
    send_card(make_card(38, 15));
    send_card(make_card(51, 16));
    send_card(make_card(55, 16));
    send_card(make_card(50, 16));
    send_card(make_card(56, 16));
    send_card(make_card(55, 15));
    send_card(make_card(40, 13));
    send_card(make_card(49, 16));
    send_card(make_card(44, 15));
    send_card(make_card(47, 14));
    send_card(spoil_check(make_card(37, 15)));
    send_card(spoil_check(make_card(42, 16)));
    drain_results();

    for (int n = 0; n < RandomItems; n++) begin
      pace_idle = !(n >= 300 && n < 420);
      if (n == 500) begin
        drain_results();
      end
      send_card(random_card());
    end

    drain_results();
    repeat (2 * Latency) @(posedge clk);
    if (fail_count == 0) begin
      $display("luhn_card_number_classifier verification clean");
    end else begin
      $display("luhn_card_number_classifier verification failed");
    end
    $finish;
  end

endmodule
